>>> design/pepf_pkg.sv
package pepf_pkg;

   // Table geometry.
   localparam int MAX_VERTICES = 16;
   localparam int INDEX_W      = $clog2(MAX_VERTICES);
   localparam int COUNT_W      = INDEX_W + 1;
   localparam int FIRST_RING   = 4;

   // Field widths.
   localparam int COORD_W      = 16;
   localparam int VERTEX_W     = 2 * COORD_W;
   localparam int TOL_W        = 15;
   localparam int VCOUNT_W     = 5;

   // Configuration port.
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = TOL_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE    = 1'b1;

   // Request opcodes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                       opcode;
      logic [INDEX_W-1:0]         vertex_index;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
   } pepf_req_type;

   typedef struct packed {
      logic                       found;
      logic [INDEX_W-1:0]         edge_index;
      logic signed [COORD_W-1:0]  start_x;
      logic signed [COORD_W-1:0]  start_y;
      logic signed [COORD_W-1:0]  end_x;
      logic signed [COORD_W-1:0]  end_y;
      logic                       last;
   } pepf_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 write;
      logic                 capture;
      logic                 issue;
      logic                 finish;
      logic [INDEX_W-1:0]   edge_idx;
   } pepf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [COUNT_W-1:0]   count;
   } pepf_status_type;

endpackage

>>> design/polygon_edge_point_finder_core.sv
// Write items may follow back to back.
// A query over n active vertices (n >= 1) holds busy through the walk, one edge per cycle,
// then a flush step and a finish step; an empty table goes straight to the finish step.
// A new item is accepted only while idle. A hit leaves when the next hit is found or at
// the close. The receiver cannot stall.
// Synchronous reset sets vertex_count to 0 and tolerance to 1; the vertex table is not cleared.
module polygon_edge_point_finder_core
   import pepf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  pepf_req_type            req_data,
   output logic                    rsp_strobe,
   output pepf_rsp_type            rsp_data,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data
);

   pepf_cmd_type    cmd;
   pepf_status_type status;

   // Sequencer for the edge walk.
   pepf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_data.opcode),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Vertex table, edge test and result registers.
   pepf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data)
   );

endmodule

>>> design/pepf_ctrl.sv
module pepf_ctrl
   import pepf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            opcode,
   input  pepf_status_type status,
   output pepf_cmd_type    cmd,
   output logic            busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [INDEX_W-1:0] idx_ff;
   logic [INDEX_W-1:0] idx_in;
   logic               accept;
   logic [COUNT_W-1:0] idx_plus;

   assign accept   = start && (state_ff == ST_IDLE);
   assign idx_plus = {1'b0, idx_ff} + COUNT_W'(1);

   // Next state: walk one edge per cycle, then let the pipeline drain.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (opcode == OP_QUERY)) begin
               idx_in   = '0;
               state_in = (status.count == '0) ? ST_FINISH : ST_WALK;
            end
         end
         ST_WALK: begin
            if (idx_plus == status.count) begin
               state_in = ST_FLUSH;
            end else begin
               idx_in = idx_plus[INDEX_W-1:0];
            end
         end
         ST_FLUSH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Commands to the datapath.
   always_comb begin
      cmd.write    = accept && (opcode == OP_WRITE);
      cmd.capture  = accept && (opcode == OP_QUERY);
      cmd.issue    = (state_ff == ST_WALK);
      cmd.finish   = (state_ff == ST_FINISH);
      cmd.edge_idx = idx_ff;
   end

   assign busy = (state_ff != ST_IDLE);

   // The walk never addresses an edge beyond the active vertex count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ({1'b0, idx_ff} < status.count))
      else $error("edge walk ran past the vertex count");

   // A query always closes with exactly one finish cycle, then goes idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (state_ff == ST_IDLE))
      else $error("finish did not return to idle");

   // An empty table goes straight to the finish cycle.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && (status.count == '0)) |=> (state_ff == ST_FINISH))
      else $error("empty query did not finish at once");

endmodule

>>> design/pepf_datapath.sv
module pepf_datapath
   import pepf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  pepf_cmd_type            cmd,
   input  pepf_req_type            req_data,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   output pepf_status_type         status,
   output logic                    rsp_strobe,
   output pepf_rsp_type            rsp_data
);

   // Absolute difference of two signed coordinates.
   function automatic logic [COORD_W:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      return d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
   endfunction

   // True when p lies between a and b inclusive, in either order.
   function automatic logic between(input logic signed [COORD_W-1:0] p,
                                    input logic signed [COORD_W-1:0] a,
                                    input logic signed [COORD_W-1:0] b);
      return ((p <= a) && (p >= b)) || ((p >= a) && (p <= b));
   endfunction

   // Configuration registers.
   logic [VCOUNT_W-1:0]        vertex_count_ff;
   logic [TOL_W-1:0]           tolerance_ff;

   // Vertex table and a per-entry origin flag written along with it.
   logic [VERTEX_W-1:0]        vertex_mem_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]    zero_flag_ff;

   // Query context.
   logic signed [COORD_W-1:0]  px_ff;
   logic signed [COORD_W-1:0]  py_ff;
   logic                       split_ff;
   logic                       split_in;
   logic [COUNT_W-1:0]         count_sat;
   logic [MAX_VERTICES-1:0]    origin_hits;

   // Edge addressing.
   logic [COUNT_W-1:0]         idx_plus;
   logic [INDEX_W-1:0]         next_idx;

   // Read stage.
   logic                       s1_valid_ff;
   logic [INDEX_W-1:0]         s1_idx_ff;
   logic [VERTEX_W-1:0]        s1_start_ff;
   logic [VERTEX_W-1:0]        s1_end_ff;

   // Edge test.
   logic signed [COORD_W-1:0]  ax;
   logic signed [COORD_W-1:0]  ay;
   logic signed [COORD_W-1:0]  bx;
   logic signed [COORD_W-1:0]  by;
   logic [COORD_W:0]           tol_ext;
   logic                       vert;
   logic                       horz;
   logic                       hit;
   pepf_rsp_type               hit_data;

   // Pending hit and result registers.
   logic                       pend_valid_ff;
   logic                       pend_valid_in;
   pepf_rsp_type               pend_data_ff;
   pepf_rsp_type               pend_data_in;
   logic                       rsp_strobe_ff;
   logic                       rsp_strobe_in;
   pepf_rsp_type               rsp_data_ff;
   pepf_rsp_type               rsp_data_in;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
         tolerance_ff    <= TOL_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_write_data[VCOUNT_W-1:0];
            CSR_TOLERANCE:    tolerance_ff    <= csr_write_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // The count saturates at the table depth.
   always_comb begin
      if (COUNT_W'(vertex_count_ff) > COUNT_W'(MAX_VERTICES)) begin
         count_sat = COUNT_W'(MAX_VERTICES);
      end else begin
         count_sat = COUNT_W'(vertex_count_ff);
      end
   end

   assign status.count = count_sat;

   // Vertex table write port; the origin flag follows each write.
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         vertex_mem_ff[req_data.vertex_index] <= {req_data.coord_y, req_data.coord_x};
         zero_flag_ff[req_data.vertex_index]  <= (req_data.coord_x == '0) &&
                                                 (req_data.coord_y == '0);
      end
   end

   // Origin scan over the active entries, taken when the query is accepted.
   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         origin_hits[j] = zero_flag_ff[j] && (COUNT_W'(j) < count_sat);
      end
      split_in = (|origin_hits) && (count_sat >= COUNT_W'(FIRST_RING));
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff    <= req_data.coord_x;
         py_ff    <= req_data.coord_y;
         split_ff <= split_in;
      end
   end

   // End vertex of the current edge, following one or two rings.
   always_comb begin
      idx_plus = {1'b0, cmd.edge_idx} + COUNT_W'(1);
      if (split_ff && ({1'b0, cmd.edge_idx} < COUNT_W'(FIRST_RING))) begin
         next_idx = (idx_plus == COUNT_W'(FIRST_RING)) ? '0 : idx_plus[INDEX_W-1:0];
      end else if (split_ff) begin
         next_idx = (idx_plus < count_sat) ? idx_plus[INDEX_W-1:0]
                                           : INDEX_W'(FIRST_RING);
      end else begin
         next_idx = (idx_plus < count_sat) ? idx_plus[INDEX_W-1:0] : '0;
      end
   end

   // Two read ports with registered data.
   always_ff @(posedge clock) begin
      s1_start_ff <= vertex_mem_ff[cmd.edge_idx];
      s1_end_ff   <= vertex_mem_ff[next_idx];
      s1_idx_ff   <= cmd.edge_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
   end

   // Point-on-edge test against the registered edge.
   always_comb begin
      ax      = s1_start_ff[COORD_W-1:0];
      ay      = s1_start_ff[VERTEX_W-1:COORD_W];
      bx      = s1_end_ff[COORD_W-1:0];
      by      = s1_end_ff[VERTEX_W-1:COORD_W];
      tol_ext = (COORD_W+1)'(tolerance_ff);
      vert    = (abs_diff(px_ff, ax) < tol_ext) && (abs_diff(px_ff, bx) < tol_ext);
      horz    = (abs_diff(py_ff, ay) < tol_ext) && (abs_diff(py_ff, by) < tol_ext);
      hit     = s1_valid_ff && ((vert && between(py_ff, ay, by)) ||
                                (horz && between(px_ff, ax, bx)));

      hit_data.found      = 1'b1;
      hit_data.edge_index = s1_idx_ff;
      hit_data.start_x    = ax;
      hit_data.start_y    = ay;
      hit_data.end_x      = bx;
      hit_data.end_y      = by;
      hit_data.last       = 1'b0;
   end

   // A hit is held back until the next hit or the close, so that the final one can carry last.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = pend_data_ff;
      if (cmd.capture) begin
         pend_valid_in = 1'b0;
      end
      if (hit) begin
         pend_valid_in = 1'b1;
         pend_data_in  = hit_data;
         rsp_strobe_in = pend_valid_ff;
      end
      if (cmd.finish) begin
         pend_valid_in = 1'b0;
         rsp_strobe_in = 1'b1;
         if (!pend_valid_ff) begin
            rsp_data_in = '0;
         end
         rsp_data_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // The pipeline is empty by the time the final result is formed.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.finish && s1_valid_ff))
      else $error("finish overlaps an edge still in the pipeline");

   // A no-hit result is always the closing one and carries no edge.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_data_ff.found) |->
      (rsp_data_ff.last && (rsp_data_ff.edge_index == '0)))
      else $error("malformed no-hit result");

   // Only the finish cycle produces a result marked last.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_data_ff.last) |-> $past(cmd.finish))
      else $error("last set outside the finish cycle");

   // Nothing is pending once a query has closed.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !pend_valid_ff)
      else $error("pending hit left after finish");

endmodule

>>> sim/polygon_edge_point_finder_core_tb.sv
`timescale 1ns / 100ps

module polygon_edge_point_finder_core_tb;
   import pepf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 25;
   localparam int IDLE_PERCENT   = 11;
   localparam int QUIET_FIRST    = 1200;
   localparam int QUIET_LAST     = 2000;
   localparam int PHASE_ITEMS    = 20;
   localparam int PHASE_NUM      = 9;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   start            = 1'b0;
   logic                   busy;
   pepf_req_type           req_data         = '0;
   logic                   rsp_strobe;
   pepf_rsp_type           rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_VERTEX_COUNT;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   // Requests waiting to be sent, and edge hits the block still owes us.
   pepf_req_type pending_q[$];
   pepf_rsp_type edge_hit_q[$];

   // Vertex table and register values as the block should hold them.
   logic [VERTEX_W-1:0] vertex_shadow [MAX_VERTICES];
   logic [VCOUNT_W-1:0] count_setting = '0;
   logic [TOL_W-1:0]    tol_setting   = TOL_W'(1);

   // Table as it will stand once every queued write has gone in.
   logic [VERTEX_W-1:0] planned_table [MAX_VERTICES] = '{default: '0};

   int error_count  = 0;
   int cycle_count  = 0;
   int quiet_cycles = 0;

   polygon_edge_point_finder_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic int abs_diff(int a, int b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic spans(int p, int a, int b);
      return (p <= a && p >= b) || (p >= a && p <= b);
   endfunction

   // True when the point sits on an edge that is vertical or horizontal within tolerance.
   function automatic logic point_on_edge(int px, int py, logic [VERTEX_W-1:0] s,
                                          logic [VERTEX_W-1:0] e, int tol);
      int   ax, ay, bx, by;
      logic vert, horz;
      ax   = $signed(s[COORD_W-1:0]);
      ay   = $signed(s[VERTEX_W-1:COORD_W]);
      bx   = $signed(e[COORD_W-1:0]);
      by   = $signed(e[VERTEX_W-1:COORD_W]);
      vert = abs_diff(px, ax) < tol && abs_diff(px, bx) < tol;
      horz = abs_diff(py, ay) < tol && abs_diff(py, by) < tol;
      return (vert && spans(py, ay, by)) || (horz && spans(px, ax, bx));
   endfunction

   // Apply one accepted transfer: a write updates the table, a query yields its edge hits.
   task automatic predict_transfer(pepf_req_type item);
      pepf_rsp_type hits[$];
      pepf_rsp_type hit;
      int           n, nxt, px, py, tol;
      logic         origin;
      if (item.opcode == OP_WRITE) begin
         vertex_shadow[item.vertex_index] = {item.coord_y, item.coord_x};
         return;
      end
      px     = $signed(item.coord_x);
      py     = $signed(item.coord_y);
      tol    = tol_setting;
      n      = (count_setting > MAX_VERTICES) ? MAX_VERTICES : count_setting;
      origin = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (vertex_shadow[i] == '0) origin = 1'b1;
      end
      // Walk the edges; an origin vertex splits the table into two rings.
      for (int i = 0; i < n; i++) begin
         if (origin && n >= FIRST_RING) begin
            if (i < FIRST_RING) nxt = (i + 1) % FIRST_RING;
            else nxt = (i + 1 < n) ? i + 1 : FIRST_RING;
         end else begin
            nxt = (i + 1 < n) ? i + 1 : 0;
         end
         if (point_on_edge(px, py, vertex_shadow[i], vertex_shadow[nxt], tol)) begin
            hit            = '0;
            hit.found      = 1'b1;
            hit.edge_index = INDEX_W'(i);
            hit.start_x    = vertex_shadow[i][COORD_W-1:0];
            hit.start_y    = vertex_shadow[i][VERTEX_W-1:COORD_W];
            hit.end_x      = vertex_shadow[nxt][COORD_W-1:0];
            hit.end_y      = vertex_shadow[nxt][VERTEX_W-1:COORD_W];
            hits = {hits, hit};
         end
      end
      // A query with no hit still answers once, with everything cleared.
      if (hits.size() == 0) begin
         hit = '0;
         hits = {hits, hit};
      end
      foreach (hits[k]) begin
         hit      = hits[k];
         hit.last = (k == hits.size() - 1);
         edge_hit_q = {edge_hit_q, hit};
      end
   endtask

   // Driver: hold the request until it is taken, otherwise maybe stay idle.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_transfer(req_data);
            void'(pending_q.pop_front());
         end
         if (!(start && busy)) begin
            if (pending_q.size() != 0 &&
                !(($urandom_range(0, 99) < IDLE_PERCENT) &&
                  (cycle_count < QUIET_FIRST || cycle_count > QUIET_LAST))) begin
               start    <= 1'b1;
               req_data <= pending_q[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobed result must match the oldest expected edge hit.
   always @(posedge clock) begin
      pepf_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (edge_hit_q.size() == 0) begin
            report_mismatch("result with nothing expected, edge_index",
                            rsp_data.edge_index, -1);
         end else begin
            want = edge_hit_q.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch("found", rsp_data.found, want.found);
            if (rsp_data.edge_index !== want.edge_index)
               report_mismatch("edge_index", rsp_data.edge_index, want.edge_index);
            if (rsp_data.start_x !== want.start_x)
               report_mismatch("start_x", rsp_data.start_x, want.start_x);
            if (rsp_data.start_y !== want.start_y)
               report_mismatch("start_y", rsp_data.start_y, want.start_y);
            if (rsp_data.end_x !== want.end_x)
               report_mismatch("end_x", rsp_data.end_x, want.end_x);
            if (rsp_data.end_y !== want.end_y)
               report_mismatch("end_y", rsp_data.end_y, want.end_y);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   // Watchdog: give up when nothing has been transferred for too long.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("FAIL polygon_edge_point_finder_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Wait until every request is sent and answered, then let the block settle.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_q.size() != 0 || edge_hit_q.size() != 0 || start);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register writes happen only with the block idle.
   task automatic write_settings(int count, int tol);
      wait_until_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_VERTEX_COUNT;
      csr_write_data   <= CSR_DATA_W'(count);
      count_setting     = VCOUNT_W'(count);
      @(posedge clock);
      csr_index        <= CSR_TOLERANCE;
      csr_write_data   <= CSR_DATA_W'(tol);
      tol_setting       = TOL_W'(tol);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_vertex(int slot, int x, int y);
      pepf_req_type item;
      item.opcode       = OP_WRITE;
      item.vertex_index = INDEX_W'(slot);
      item.coord_x      = COORD_W'(x);
      item.coord_y      = COORD_W'(y);
      planned_table[slot] = {item.coord_y, item.coord_x};
      pending_q = {pending_q, item};
   endtask

   task automatic queue_query(int x, int y);
      pepf_req_type item;
      item.opcode       = OP_QUERY;
      item.vertex_index = INDEX_W'($urandom_range(0, MAX_VERTICES - 1));
      item.coord_x      = COORD_W'(x);
      item.coord_y      = COORD_W'(y);
      pending_q = {pending_q, item};
   endtask

   function automatic int grid_coord();
      int g;
      g = $urandom_range(0, 16);
      return (g - 8) * 256;
   endfunction

   function automatic int pick_between(int a, int b);
      int lo, hi, r;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      r  = $urandom_range(0, hi - lo);
      return lo + r;
   endfunction

   // Mostly extend the previous vertex along one axis so that edges stay aligned.
   task automatic random_vertex(int slot);
      logic [VERTEX_W-1:0] prev;
      int                  x, y;
      prev = planned_table[(slot + MAX_VERTICES - 1) % MAX_VERTICES];
      x    = $signed(prev[COORD_W-1:0]);
      y    = $signed(prev[VERTEX_W-1:COORD_W]);
      case ($urandom_range(0, 9))
         0: begin
            x = $urandom;
            y = $urandom;
         end
         1: begin
            x = 0;
            y = 0;
         end
         2, 3, 4, 5: y = grid_coord();
         default: x = grid_coord();
      endcase
      queue_vertex(slot, x, y);
   endtask

   // Mostly aim at a point on a planned edge, sometimes nudged, else anywhere.
   task automatic random_query();
      int n, i, nxt, ax, ay, bx, by, px, py, jitter;
      n = (count_setting > MAX_VERTICES) ? MAX_VERTICES : count_setting;
      if (n > 0 && $urandom_range(0, 9) < 7) begin
         i   = $urandom_range(0, n - 1);
         nxt = (i + 1 < n) ? i + 1 : 0;
         ax  = $signed(planned_table[i][COORD_W-1:0]);
         ay  = $signed(planned_table[i][VERTEX_W-1:COORD_W]);
         bx  = $signed(planned_table[nxt][COORD_W-1:0]);
         by  = $signed(planned_table[nxt][VERTEX_W-1:COORD_W]);
         if (ax == bx) begin
            px = ax;
            py = pick_between(ay, by);
         end else if (ay == by) begin
            py = ay;
            px = pick_between(ax, bx);
         end else begin
            px = ax;
            py = ay;
         end
         if ($urandom_range(0, 3) == 0) begin
            jitter = $urandom_range(0, 4);
            px     = px + jitter - 2;
            jitter = $urandom_range(0, 4);
            py     = py + jitter - 2;
         end
      end else if ($urandom_range(0, 1) == 0) begin
         px = $urandom;
         py = $urandom;
      end else begin
         px = grid_coord();
         py = grid_coord();
      end
      queue_query(px, py);
   endtask

   // Stimulus: directed corner cases, then random phases under varied settings.
   initial begin
      int phase_counts [PHASE_NUM];
      int phase_tols   [PHASE_NUM];
      phase_counts = '{16, 4, 31, 9, 16, 0, 12, 2, 16};
      phase_tols   = '{1, $urandom_range(2, 600), 32767, 0, $urandom_range(2, 64),
                       1, $urandom_range(100, 2000), 1, 3};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty table after reset answers with a single miss.
      queue_query(0, 0);
      // A square around the origin, without the origin itself.
      queue_vertex(0, -256, -256);
      queue_vertex(1, 256, -256);
      queue_vertex(2, 256, 256);
      queue_vertex(3, -256, 256);
      write_settings(4, 1);
      queue_query(256, 0);
      queue_query(-256, -256);
      queue_query(0, 0);
      queue_query(-32768, 32767);
      // Zero tolerance never matches.
      write_settings(4, 0);
      queue_query(256, 0);
      // Origin present: two rings, the second one along the coordinate extremes.
      queue_vertex(4, 0, 0);
      queue_vertex(5, 32767, -32768);
      queue_vertex(6, -32768, -32768);
      queue_vertex(7, -32768, 32767);
      write_settings(8, 2);
      queue_query(-32768, 0);
      queue_query(32767, -32768);
      // Origin with fewer than four vertices stays a single ring.
      queue_vertex(1, 0, 0);
      queue_vertex(2, 0, 256);
      write_settings(3, 1);
      queue_query(0, 128);

      // Fill the whole table so that any count reads written entries only.
      for (int s = 0; s < MAX_VERTICES; s++) random_vertex(s);

      for (int p = 0; p < PHASE_NUM; p++) begin
         write_settings(phase_counts[p], phase_tols[p]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 3) == 0) random_vertex($urandom_range(0, MAX_VERTICES - 1));
            else random_query();
         end
      end

      wait_until_drained();
      if (error_count == 0) begin
         $display("PASS polygon_edge_point_finder_core");
      end else begin
         $display("FAIL polygon_edge_point_finder_core");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/pepf_pkg.sv
design/pepf_ctrl.sv
design/pepf_datapath.sv
design/polygon_edge_point_finder_core.sv
sim/polygon_edge_point_finder_core_tb.sv
